>>> hw/rtl/signed_int_to_radix_digits_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix digits core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SITRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitrd assertion failed");
// next-cycle implication
`define SITRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitrd assertion failed");
`else
`define SITRD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SITRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/sitrd_pkg.sv
// ----------------------------------------------------------------------------
// sitrd_pkg
// Shared types, constants and helpers of the radix digits core.
// ----------------------------------------------------------------------------
package sitrd_pkg;

  localparam int NUMBER_W    = 32;
  localparam int CHAR_W      = 8;
  localparam int ALPHA_W     = 64;
  localparam int MAX_RADIX   = 16;
  localparam int RADIX_W     = $clog2(MAX_RADIX + 1);
  localparam int DIGIT_W     = $clog2(MAX_RADIX);
  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // one classified number on its way to the converter
  typedef struct packed {
    logic                neg;
    logic [NUMBER_W-1:0] magnitude;
    logic [RADIX_W-1:0]  radix;
  } sitrd_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } sitrd_state_t;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] lo,
                                                   input logic [ALPHA_W-1:0] hi,
                                                   input logic [DIGIT_W-1:0] idx);
    logic [2*ALPHA_W-1:0] all;
    all = {hi, lo};
    return all[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

>>> hw/rtl/sitrd_queue.sv
// ----------------------------------------------------------------------------
// sitrd_queue
// Short FIFO of classified numbers between the front and the converter.
// ----------------------------------------------------------------------------
module sitrd_queue #(
  parameter int DEPTH = sitrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sitrd_pkg::sitrd_item_t push_item,
  output logic                   ready,
  input  logic                   pop,
  output logic                   valid,
  output sitrd_pkg::sitrd_item_t pop_item
);
  import sitrd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sitrd_item_t            entries [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign ready    = count != CNT_W'(DEPTH);
  assign valid    = count != '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/sitrd_front.sv
// ----------------------------------------------------------------------------
// sitrd_front
// Accepts numbers, checks the alphabet, splits sign and magnitude.
// ----------------------------------------------------------------------------
module sitrd_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sitrd_pkg::NUMBER_W-1:0]  number,
  input  logic [sitrd_pkg::RADIX_W-1:0]          radix_length,
  input  logic [sitrd_pkg::ALPHA_W-1:0]          alphabet_low,
  input  logic [sitrd_pkg::ALPHA_W-1:0]          alphabet_high,
  output logic                                   q_push,
  output sitrd_pkg::sitrd_item_t                 q_item,
  input  logic                                   q_ready
);
  import sitrd_pkg::*;

  logic [CHAR_W-1:0]   chars [MAX_RADIX];
  logic [RADIX_W-1:0]  lim;
  logic [RADIX_W-1:0]  used;
  logic                bad;
  logic [RADIX_W-1:0]  radix;
  logic                radix_ok;

  logic                stg_valid;
  logic [NUMBER_W-1:0] stg_number;
  logic                stg_leave;
  logic                neg;

  // radix in use: clamp, stop at first zero byte, then reject repeats, signs and a radix under two
  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      chars[i] = alpha_char(alphabet_low, alphabet_high, DIGIT_W'(i));
    end
    lim = (radix_length > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_length;
    used = lim;
    for (int i = MAX_RADIX - 1; i >= 0; i--) begin
      if (RADIX_W'(i) < lim && chars[i] == '0) begin
        used = RADIX_W'(i);
      end
    end
    bad = used < RADIX_W'(2);
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < used && (chars[i] == CH_MINUS || chars[i] == CH_PLUS)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < MAX_RADIX; j++) begin
        if (RADIX_W'(j) < used && chars[i] == chars[j]) begin
          bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_ok <= 1'b0;
      radix    <= '0;
    end else begin
      radix_ok <= !bad;
      radix    <= used;
    end
  end

  // an item with a bad alphabet is dropped here
  assign stg_leave = stg_valid && (!radix_ok || q_ready);
  assign in_ready  = !stg_valid || stg_leave;
  assign neg       = stg_number[NUMBER_W-1];

  assign q_push           = stg_valid && radix_ok && q_ready;
  assign q_item.neg       = neg;
  assign q_item.magnitude = neg ? (~stg_number + NUMBER_W'(1)) : stg_number;
  assign q_item.radix     = radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_number <= number;
    end
  end

endmodule

>>> hw/rtl/sitrd_back.sv
// ----------------------------------------------------------------------------
// sitrd_back
// Converts one magnitude to digits, then streams sign and characters.
// ----------------------------------------------------------------------------
module sitrd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  sitrd_pkg::sitrd_item_t         q_item,
  output logic                           q_pop,
  input  logic [sitrd_pkg::ALPHA_W-1:0]  alphabet_low,
  input  logic [sitrd_pkg::ALPHA_W-1:0]  alphabet_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sitrd_pkg::CHAR_W-1:0]   character,
  output logic                           final_char
);
  import sitrd_pkg::*;

  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = NUMBER_W / DIV_BITS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // one byte of restoring long division by a narrow divisor
  function automatic logic [DIGIT_W+DIV_BITS-1:0] div_byte(input logic [DIGIT_W-1:0] r_in,
                                                           input logic [DIV_BITS-1:0] bits,
                                                           input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0]  r;
    logic [DIV_BITS-1:0] q;
    r = RADIX_W'(r_in);
    q = '0;
    for (int b = DIV_BITS - 1; b >= 0; b--) begin
      r = {r[DIGIT_W-1:0], bits[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return {r[DIGIT_W-1:0], q};
  endfunction

  sitrd_state_t          state;
  sitrd_state_t          state_next;

  logic                  neg;
  logic [RADIX_W-1:0]    radix;
  logic [NUMBER_W-1:0]   remaining_magnitude;
  logic [DIGIT_W-1:0]    rem;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [COUNT_W-1:0]    digit_count;
  logic [DIGIT_IDX_W-1:0] emit_idx;

  logic [DIGIT_W-1:0]    digit_buffer [MAX_DIGITS];
  logic [DIGIT_W-1:0]    rd_data;
  logic [DIGIT_IDX_W-1:0] rd_addr;

  logic [DIGIT_W-1:0]    rem_step;
  logic [DIV_BITS-1:0]   q_byte;
  logic [NUMBER_W-1:0]   quotient_next;
  logic                  div_last;
  logic                  more;
  logic                  mem_we;
  logic                  out_free;
  logic                  out_load;
  logic [CHAR_W-1:0]     load_char;
  logic                  load_final;

  assign {rem_step, q_byte} = div_byte(rem, remaining_magnitude[NUMBER_W-1 -: DIV_BITS], radix);
  assign quotient_next = {remaining_magnitude[NUMBER_W-DIV_BITS-1:0], q_byte};
  assign div_last      = div_cnt == DIV_CNT_W'(DIV_CYCLES - 1);
  assign more          = quotient_next != '0 && digit_count < COUNT_W'(MAX_DIGITS - 1);
  assign out_free      = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    load_char  = CH_MINUS;
    load_final = 1'b0;
    rd_addr    = emit_idx;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_last) begin
          mem_we = 1'b1;
          if (!more) begin
            state_next = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        // also lets the registered read of the top digit land before ST_EMIT uses it
        if (!neg) begin
          state_next = ST_EMIT;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        load_char  = alpha_char(alphabet_low, alphabet_high, rd_data);
        load_final = emit_idx == '0;
        if (out_free) begin
          out_load = 1'b1;
          if (emit_idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            rd_addr = emit_idx - 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      out_valid           <= 1'b0;
      digit_count         <= '0;
      remaining_magnitude <= '0;
      div_cnt             <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        remaining_magnitude <= q_item.magnitude;
        digit_count         <= '0;
        div_cnt             <= '0;
      end else if (state == ST_DIVIDE) begin
        remaining_magnitude <= quotient_next;
        div_cnt             <= div_last ? '0 : div_cnt + 1'b1;
        if (div_last) begin
          digit_count <= digit_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg   <= q_item.neg;
      radix <= q_item.radix;
      rem   <= '0;
    end else if (state == ST_DIVIDE) begin
      rem <= div_last ? '0 : rem_step;
      if (div_last) begin
        emit_idx <= digit_count[DIGIT_IDX_W-1:0];
      end
    end else if (state == ST_EMIT && out_load && emit_idx != '0) begin
      emit_idx <= emit_idx - 1'b1;
    end
    if (out_load) begin
      character  <= load_char;
      final_char <= load_final;
    end
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_buffer[digit_count[DIGIT_IDX_W-1:0]] <= rem_step;
    end
    rd_data <= digit_buffer[rd_addr];
  end

endmodule

>>> hw/rtl/signed_int_to_radix_digits_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_core
// Writes signed 32-bit numbers as characters of a configured digit alphabet.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one number per beat; output channel
// out_valid/out_ready carries one character per beat, final_char marking the
// last one of a number. A negative number starts with '-'.
// Configure with cfg_we/cfg_index/cfg_data while the core is idle: index 0 is
// the radix length, 1 and 2 the low and high eight alphabet bytes.
// A number passes the front stage register and the queue; the converter then
// divides 8 bits per cycle, passes ST_SIGN, where a negative number emits its
// '-', and emits one character per cycle while out_ready does not stall it.
// The queue holds two classified numbers, so the front keeps accepting while
// the converter works or the receiver stalls; a stalled receiver holds the
// converter, then the queue fills and in_ready drops.
// Reset clears the configuration, which leaves the alphabet invalid: numbers
// are then taken and dropped without any character.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_digits_core_defines.svh"

module signed_int_to_radix_digits_core #(
  parameter int QUEUE_DEPTH = sitrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sitrd_pkg::NUMBER_W-1:0]  number,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sitrd_pkg::CHAR_W-1:0]           character,
  output logic                                   final_char,
  input  logic                                   cfg_we,
  input  logic [sitrd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sitrd_pkg::ALPHA_W-1:0]          cfg_data
);
  import sitrd_pkg::*;

  logic [RADIX_W-1:0] radix_length;
  logic [ALPHA_W-1:0] alphabet_low;
  logic [ALPHA_W-1:0] alphabet_high;

  logic               q_push;
  logic               q_ready;
  logic               q_pop;
  logic               q_valid;
  sitrd_item_t        push_item;
  sitrd_item_t        pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length  <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX_LENGTH:  radix_length  <= cfg_data[RADIX_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  sitrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .number        (number),
    .radix_length  (radix_length),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .q_push        (q_push),
    .q_item        (push_item),
    .q_ready       (q_ready)
  );

  sitrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  sitrd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .character     (character),
    .final_char    (final_char)
  );

  `SITRD_ASSERT_IMPL(a_push_has_room, clk, rst, q_push, q_ready)
  `SITRD_ASSERT_IMPL(a_pop_has_item, clk, rst, q_pop, q_valid)
  `SITRD_ASSERT_NEXT(a_one_at_a_time, clk, rst, q_pop, !q_pop)

endmodule
